// ----- rtl/smwt_pkg.sv -----
`timescale 1ns / 1ps
package smwt_pkg;

    localparam int DEF_ANGLE_BITS         = 16;
    localparam int DEF_THROTTLE_FRAC_BITS = 15;

    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_CAP = 1'd1;

    localparam logic [VAL_W-1:0] WINDOW_HALF_RST  = 16'd8192;
    localparam logic [VAL_W-1:0] THROTTLE_CAP_RST = 16'd32768;

    localparam int DIV_STEPS_PER_STAGE = 3;

    typedef enum logic [1:0] {
        REG_SPIN   = 2'd0,
        REG_BOOST  = 2'd1,
        REG_OPPOSE = 2'd2,
        REG_NONE   = 2'd3
    } t_region;

    typedef struct packed {
        logic [VAL_W-1:0] spin;
        logic [VAL_W-1:0] cap;
        t_region          region;
        logic             neg;
    } t_side;

endpackage

// ----- rtl/smwt_angle.sv -----
`timescale 1ns / 1ps
module smwt_angle #(
    parameter int ANGLE_BITS         = smwt_pkg::DEF_ANGLE_BITS,
    parameter int THROTTLE_FRAC_BITS = smwt_pkg::DEF_THROTTLE_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ANGLE_BITS-1:0]       i_motor_angle,
    input  logic [ANGLE_BITS-1:0]       i_translation_angle,
    input  logic [smwt_pkg::VAL_W-1:0]  i_translation_magnitude,
    input  logic [smwt_pkg::VAL_W-1:0]  i_spin_throttle,
    input  logic [smwt_pkg::VAL_W-1:0]  i_window_half,
    input  logic [smwt_pkg::VAL_W-1:0]  i_throttle_cap,
    output logic                        o_valid,
    output logic [smwt_pkg::VAL_W-1:0]  o_mag,
    output logic [smwt_pkg::VAL_W-1:0]  o_oper,
    output logic [smwt_pkg::VAL_W-1:0]  o_factor,
    output logic [smwt_pkg::VAL_W-1:0]  o_wh,
    output smwt_pkg::t_side             o_side
);
    import smwt_pkg::*;

    localparam int MAG_FLOOR = ((2 ** THROTTLE_FRAC_BITS) + 999) / 1000;
    localparam int CW = ((ANGLE_BITS > VAL_W) ? ANGLE_BITS : VAL_W) + 2;
    localparam logic [CW-1:0] HALF_TURN =
        {{(CW-ANGLE_BITS){1'b0}}, 1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [ANGLE_BITS-1:0] w_d;
    logic [ANGLE_BITS-1:0] w_abs;
    logic signed [VAL_W:0] w_diff;

    logic                  r1_valid;
    logic [ANGLE_BITS-1:0] r1_a;
    logic [VAL_W-1:0]      r1_mag;
    logic [VAL_W-1:0]      r1_spin;
    logic [VAL_W-1:0]      r1_cap;
    logic [VAL_W-1:0]      r1_wh;
    logic signed [VAL_W:0] r1_diff;
    logic                  r1_small;

    assign w_d    = i_motor_angle - i_translation_angle;
    assign w_abs  = w_d[ANGLE_BITS-1] ? ((~w_d) + ANGLE_BITS'(1)) : w_d;
    assign w_diff = $signed({1'b0, i_throttle_cap}) - $signed({1'b0, i_spin_throttle});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= w_abs;
            r1_mag   <= i_translation_magnitude;
            r1_spin  <= i_spin_throttle;
            r1_cap   <= i_throttle_cap;
            r1_wh    <= i_window_half;
            r1_diff  <= w_diff;
            r1_small <= (i_translation_magnitude < VAL_W'(MAG_FLOOR));
        end
    end

    logic [CW-1:0]    w_a_ext;
    logic [CW-1:0]    w_wh_ext;
    logic             w_boost;
    logic             w_opp;
    logic [CW-1:0]    w_bfac;
    logic [CW-1:0]    w_ofac;
    logic             w_neg;
    logic [VAL_W:0]   w_dabs;
    t_region          w_region;

    assign w_a_ext  = CW'(r1_a);
    assign w_wh_ext = CW'(r1_wh);
    assign w_boost  = (w_a_ext < w_wh_ext);
    assign w_opp    = (r1_wh != '0) && ((w_a_ext + w_wh_ext) > HALF_TURN);
    assign w_bfac   = w_wh_ext - w_a_ext;
    assign w_ofac   = w_a_ext + w_wh_ext - HALF_TURN;
    assign w_neg    = r1_diff[VAL_W];
    assign w_dabs   = w_neg ? (VAL_W+1)'(-r1_diff) : (VAL_W+1)'(r1_diff);

    always_comb begin
        priority if (r1_small) begin
            w_region = REG_SPIN;
        end else if (w_boost) begin
            w_region = REG_BOOST;
        end else if (w_opp) begin
            w_region = REG_OPPOSE;
        end else begin
            w_region = REG_NONE;
        end
    end

    logic             r2_valid;
    logic [VAL_W-1:0] r2_mag;
    logic [VAL_W-1:0] r2_oper;
    logic [VAL_W-1:0] r2_factor;
    logic [VAL_W-1:0] r2_wh;
    t_side            r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag         <= r1_mag;
            r2_oper        <= w_boost ? w_dabs[VAL_W-1:0] : r1_spin;
            r2_factor      <= w_boost ? w_bfac[VAL_W-1:0] : w_ofac[VAL_W-1:0];
            r2_wh          <= r1_wh;
            r2_side.spin   <= r1_spin;
            r2_side.cap    <= r1_cap;
            r2_side.region <= w_region;
            r2_side.neg    <= w_neg;
        end
    end

    assign o_valid  = r2_valid;
    assign o_mag    = r2_mag;
    assign o_oper   = r2_oper;
    assign o_factor = r2_factor;
    assign o_wh     = r2_wh;
    assign o_side   = r2_side;

endmodule

// ----- rtl/smwt_mult.sv -----
`timescale 1ns / 1ps
module smwt_mult #(
    parameter int THROTTLE_FRAC_BITS = smwt_pkg::DEF_THROTTLE_FRAC_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  logic                                              i_valid,
    input  logic [smwt_pkg::VAL_W-1:0]                        i_mag,
    input  logic [smwt_pkg::VAL_W-1:0]                        i_oper,
    input  logic [smwt_pkg::VAL_W-1:0]                        i_factor,
    input  logic [smwt_pkg::VAL_W-1:0]                        i_wh,
    input  smwt_pkg::t_side                                   i_side,
    output logic                                              o_valid,
    output logic [3*smwt_pkg::VAL_W-THROTTLE_FRAC_BITS:0]     o_dividend,
    output logic [smwt_pkg::VAL_W-1:0]                        o_wh,
    output smwt_pkg::t_side                                   o_side
);
    import smwt_pkg::*;

    localparam int PW = 2 * VAL_W;
    localparam int NW = 3 * VAL_W;
    localparam int SW = NW + 1;
    localparam int DW = SW - THROTTLE_FRAC_BITS;

    logic             r3_valid;
    logic [PW-1:0]    r3_p;
    logic [VAL_W-1:0] r3_factor;
    logic [VAL_W-1:0] r3_wh;
    t_side            r3_side;

    logic             r4_valid;
    logic [NW-1:0]    r4_num;
    logic [VAL_W-1:0] r4_wh;
    t_side            r4_side;

    logic             r5_valid;
    logic [DW-1:0]    r5_x;
    logic [VAL_W-1:0] r5_wh;
    t_side            r5_side;

    logic             w_opp;
    logic [SW-1:0]    w_rnd;
    logic [SW-1:0]    w_sum;
    logic [DW-1:0]    w_x;

    assign w_opp = (r4_side.region == REG_OPPOSE);
    assign w_rnd = w_opp ? (SW'(r4_wh) << THROTTLE_FRAC_BITS)
                         : (SW'(r4_wh) << (THROTTLE_FRAC_BITS - 1));
    assign w_sum = SW'(r4_num) + w_rnd;
    assign w_x   = w_opp ? DW'(w_sum >> (THROTTLE_FRAC_BITS + 1))
                         : DW'(w_sum >> THROTTLE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p      <= PW'(i_mag) * PW'(i_oper);
            r3_factor <= i_factor;
            r3_wh     <= i_wh;
            r3_side   <= i_side;
            r4_num    <= NW'(r3_p) * NW'(r3_factor);
            r4_wh     <= r3_wh;
            r4_side   <= r3_side;
            r5_x      <= w_x;
            r5_wh     <= r4_wh;
            r5_side   <= r4_side;
        end
    end

    assign o_valid    = r5_valid;
    assign o_dividend = r5_x;
    assign o_wh       = r5_wh;
    assign o_side     = r5_side;

endmodule

// ----- rtl/smwt_div.sv -----
`timescale 1ns / 1ps
module smwt_div #(
    parameter int THROTTLE_FRAC_BITS = smwt_pkg::DEF_THROTTLE_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [3*smwt_pkg::VAL_W-THROTTLE_FRAC_BITS:0] i_dividend,
    input  logic [smwt_pkg::VAL_W-1:0]                    i_wh,
    input  smwt_pkg::t_side                               i_side,
    output logic                                          o_valid,
    output logic [2*smwt_pkg::VAL_W-THROTTLE_FRAC_BITS:0] o_quot,
    output smwt_pkg::t_side                               o_side
);
    import smwt_pkg::*;

    localparam int QW  = 2 * VAL_W + 1 - THROTTLE_FRAC_BITS;
    localparam int DW  = 3 * VAL_W + 1 - THROTTLE_FRAC_BITS;
    localparam int BPS = DIV_STEPS_PER_STAGE;
    localparam int NST = (QW + BPS - 1) / BPS;

    function automatic logic [VAL_W+QW-1:0] div_steps(
        input logic [VAL_W-1:0] rem,
        input logic [QW-1:0]    rq,
        input logic [VAL_W-1:0] den,
        input int               first
    );
        logic [VAL_W-1:0] r;
        logic [QW-1:0]    q;
        logic [VAL_W:0]   t;
        logic             ge;
        r = rem;
        q = rq;
        for (int j = 0; j < BPS; j++) begin
            if (first + j < QW) begin
                t  = {r, q[QW-1]};
                ge = (t >= {1'b0, den});
                q  = {q[QW-2:0], ge};
                r  = ge ? VAL_W'(t - {1'b0, den}) : t[VAL_W-1:0];
            end
        end
        return {r, q};
    endfunction

    logic             r_valid [NST];
    logic [VAL_W-1:0] r_rem   [NST];
    logic [QW-1:0]    r_rq    [NST];
    logic [VAL_W-1:0] r_wh    [NST];
    t_side            r_side  [NST];

    logic             s_valid [NST];
    logic [VAL_W-1:0] s_rem   [NST];
    logic [QW-1:0]    s_rq    [NST];
    logic [VAL_W-1:0] s_wh    [NST];
    t_side            s_side  [NST];
    logic [VAL_W+QW-1:0] n_step [NST];

    always_comb begin
        s_valid[0] = i_valid;
        s_rem[0]   = i_dividend[DW-1:QW];
        s_rq[0]    = i_dividend[QW-1:0];
        s_wh[0]    = i_wh;
        s_side[0]  = i_side;
        for (int g = 1; g < NST; g++) begin
            s_valid[g] = r_valid[g-1];
            s_rem[g]   = r_rem[g-1];
            s_rq[g]    = r_rq[g-1];
            s_wh[g]    = r_wh[g-1];
            s_side[g]  = r_side[g-1];
        end
        for (int g = 0; g < NST; g++) begin
            n_step[g] = div_steps(s_rem[g], s_rq[g], s_wh[g], g * BPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NST; g++) begin
                r_valid[g] <= 1'b0;
            end
        end else if (i_en) begin
            for (int g = 0; g < NST; g++) begin
                r_valid[g] <= s_valid[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < NST; g++) begin
                r_rem[g]  <= n_step[g][VAL_W+QW-1:QW];
                r_rq[g]   <= n_step[g][QW-1:0];
                r_wh[g]   <= s_wh[g];
                r_side[g] <= s_side[g];
            end
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_quot  = r_rq[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ----- rtl/spin_motor_window_throttle_top.sv -----
// The long division runs three quotient bits per stage.
// Throughput: one item per cycle; a stalled result holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and loads window_half = 8192,
// throttle_cap = 32768.
`timescale 1ns / 1ps
module spin_motor_window_throttle_top #(
    parameter int ANGLE_BITS         = smwt_pkg::DEF_ANGLE_BITS,
    parameter int THROTTLE_FRAC_BITS = smwt_pkg::DEF_THROTTLE_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [smwt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smwt_pkg::VAL_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ANGLE_BITS-1:0]               i_motor_angle,
    input  logic [ANGLE_BITS-1:0]               i_translation_angle,
    input  logic [smwt_pkg::VAL_W-1:0]          i_translation_magnitude,
    input  logic [smwt_pkg::VAL_W-1:0]          i_spin_throttle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [smwt_pkg::VAL_W-1:0]          o_motor_throttle,
    output logic [1:0]                          o_region
);
    import smwt_pkg::*;

    localparam int QW = 2 * VAL_W + 1 - THROTTLE_FRAC_BITS;
    localparam int DW = 3 * VAL_W + 1 - THROTTLE_FRAC_BITS;
    localparam int RW = ((QW > VAL_W) ? QW : VAL_W) + 2;

    logic [VAL_W-1:0] r_window_half;
    logic [VAL_W-1:0] r_throttle_cap;
    logic             w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_half  <= WINDOW_HALF_RST;
            r_throttle_cap <= THROTTLE_CAP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WINDOW_HALF:  r_window_half  <= i_cfg_data;
                CFG_THROTTLE_CAP: r_throttle_cap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic             r_out_valid;
    logic [VAL_W-1:0] r_throttle;
    logic [1:0]       r_region;

    assign o_stall = r_out_valid & i_stall;
    assign w_en    = ~o_stall;

    logic             w_ang_valid;
    logic [VAL_W-1:0] w_ang_mag;
    logic [VAL_W-1:0] w_ang_oper;
    logic [VAL_W-1:0] w_ang_factor;
    logic [VAL_W-1:0] w_ang_wh;
    t_side            w_ang_side;

    smwt_angle #(
        .ANGLE_BITS         (ANGLE_BITS),
        .THROTTLE_FRAC_BITS (THROTTLE_FRAC_BITS)
    ) u_angle (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_en                    (w_en),
        .i_valid                 (i_valid),
        .i_motor_angle           (i_motor_angle),
        .i_translation_angle     (i_translation_angle),
        .i_translation_magnitude (i_translation_magnitude),
        .i_spin_throttle         (i_spin_throttle),
        .i_window_half           (r_window_half),
        .i_throttle_cap          (r_throttle_cap),
        .o_valid                 (w_ang_valid),
        .o_mag                   (w_ang_mag),
        .o_oper                  (w_ang_oper),
        .o_factor                (w_ang_factor),
        .o_wh                    (w_ang_wh),
        .o_side                  (w_ang_side)
    );

    logic             w_mul_valid;
    logic [DW-1:0]    w_mul_dividend;
    logic [VAL_W-1:0] w_mul_wh;
    t_side            w_mul_side;

    smwt_mult #(
        .THROTTLE_FRAC_BITS (THROTTLE_FRAC_BITS)
    ) u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_ang_valid),
        .i_mag      (w_ang_mag),
        .i_oper     (w_ang_oper),
        .i_factor   (w_ang_factor),
        .i_wh       (w_ang_wh),
        .i_side     (w_ang_side),
        .o_valid    (w_mul_valid),
        .o_dividend (w_mul_dividend),
        .o_wh       (w_mul_wh),
        .o_side     (w_mul_side)
    );

    logic          w_div_valid;
    logic [QW-1:0] w_quot;
    t_side         w_div_side;

    smwt_div #(
        .THROTTLE_FRAC_BITS (THROTTLE_FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_mul_valid),
        .i_dividend (w_mul_dividend),
        .i_wh       (w_mul_wh),
        .i_side     (w_mul_side),
        .o_valid    (w_div_valid),
        .o_quot     (w_quot),
        .o_side     (w_div_side)
    );

    logic signed [RW-1:0] w_spin_s;
    logic signed [RW-1:0] w_cap_s;
    logic signed [RW-1:0] w_q_s;
    logic signed [RW-1:0] w_delta;
    logic signed [RW-1:0] w_res;
    logic [VAL_W-1:0]     n_throttle;

    assign w_spin_s = $signed(RW'(w_div_side.spin));
    assign w_cap_s  = $signed(RW'(w_div_side.cap));
    assign w_q_s    = $signed(RW'(w_quot));

    always_comb begin
        unique case (w_div_side.region)
            REG_BOOST:  w_delta = w_div_side.neg ? -w_q_s : w_q_s;
            REG_OPPOSE: w_delta = -w_q_s;
            default:    w_delta = '0;
        endcase
    end

    assign w_res = w_spin_s + w_delta;

    always_comb begin
        priority if (w_res < 0) begin
            n_throttle = '0;
        end else if (w_res > w_cap_s) begin
            n_throttle = w_div_side.cap;
        end else begin
            n_throttle = w_res[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_throttle <= n_throttle;
            r_region   <= w_div_side.region;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_motor_throttle = r_throttle;
    assign o_region         = r_region;

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting result");

    a_oppose_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid && (w_div_side.region == REG_OPPOSE))
        |-> (RW'(w_quot) <= RW'(w_div_side.spin)))
        else $error("opposing cut exceeds spin throttle");

    a_boost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid && (w_div_side.region == REG_BOOST) && !w_div_side.neg)
        |-> (RW'(w_quot) <= (RW'(w_div_side.cap) - RW'(w_div_side.spin))))
        else $error("boost exceeds headroom to cap");
`endif

endmodule
